/* src/edf_ready_queue_macros.svh */
// Assertion helpers used by the ready queue top level.
`ifndef EDF_READY_QUEUE_MACROS_SVH
`define EDF_READY_QUEUE_MACROS_SVH

// Clocked property that is ignored while reset is held.
`define EDFQ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property that also holds during reset.
`define EDFQ_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/edfq_pkg.sv */
package edfq_pkg;

    localparam int TASK_W   = 6;
    localparam int DL_W     = 32;
    localparam int STATUS_W = 2;

    // Command codes carried on the input tuser.
    localparam logic CMD_RELEASE  = 1'b0;
    localparam logic CMD_COMPLETE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // Operation broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_INSERT,
        CELL_STEP,
        CELL_REMOVE
    } cell_op_t;

    // One queue entry as it moves between neighboring cells.
    typedef struct packed {
        logic              valid;
        logic [TASK_W-1:0] task_id;
        logic [DL_W-1:0]   deadline;
    } entry_t;

    // Broadcast control: the operation and the latched item.
    typedef struct packed {
        cell_op_t          op;
        logic [TASK_W-1:0] task_id;
        logic [DL_W-1:0]   deadline;
    } cell_ctrl_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_WAVE,
        S_REMOVE,
        S_RESULT
    } seq_state_t;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        cell_op_t op;
        logic     capture_insert;
        logic     capture_remove;
        logic     load_result;
        logic     idle;
    } seq_ctrl_t;

endpackage

/* src/edf_ready_queue.sv */
// Channel  Direction  tuser                 tdata (lowest bit first)
// s_       in         cmd                   task_id, deadline
// m_       out        status                head_valid, head_task, preempt,
//                                           demoted_task, promote
//
// A release passes from the insert state to the result state; a completion
// first walks the found-before flag down the row one cell a cycle.
// Insert shifts the whole cell row at once; removal shifts it once the
// walk has settled. One item is in work at a time; an item is taken while a
// result still waits in the output register. Reset empties the queue at once.
// A stalled output holds the sequencer in its result state.
`include "edf_ready_queue_macros.svh"

module edf_ready_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // task_id[5:0], deadline[37:6], zero
    input  logic [0:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // head_valid, head_task, preempt, demoted_task, promote
    output logic [1:0]  m_tuser    // status
);
    import edfq_pkg::*;

    localparam int LAST = QUEUE_DEPTH - 1;

    seq_ctrl_t  seq;
    cell_ctrl_t ctrl;
    entry_t     cell_q  [QUEUE_DEPTH];
    entry_t     left_e  [QUEUE_DEPTH];
    entry_t     right_e [QUEUE_DEPTH];
    logic       lt_v    [QUEUE_DEPTH];
    logic       left_lt [QUEUE_DEPTH];
    logic       match_v [QUEUE_DEPTH];
    logic       found_v [QUEUE_DEPTH];
    logic       left_fd [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_vec;

    logic              accept;
    logic              out_free;
    logic              full;
    logic [TASK_W-1:0] tid_reg;
    logic [DL_W-1:0]   dl_reg;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic                preempt_reg, preempt_next;
    logic [TASK_W-1:0]   demoted_reg, demoted_next;
    logic                head_rm_reg, head_rm_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = seq.idle;
    assign out_free = !m_tvalid_reg || m_tready;
    assign full     = cell_q[LAST].valid;

    edfq_seq #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .cmd     (s_tuser[0]),
        .out_free(out_free),
        .seq     (seq)
    );

    // Latch the item being worked on.
    always_ff @(posedge aclk) begin
        if (accept) begin
            tid_reg <= s_tdata[TASK_W-1:0];
            dl_reg  <= s_tdata[TASK_W+DL_W-1:TASK_W];
        end
    end

    // A release into a full queue leaves the cells untouched.
    always_comb begin
        ctrl.op       = (seq.op == CELL_INSERT && full) ? CELL_HOLD : seq.op;
        ctrl.task_id  = tid_reg;
        ctrl.deadline = dl_reg;
    end

    // The row of cells, slot 0 at the head.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_e[i]  = '0;
            assign left_lt[i] = 1'b0;
            assign left_fd[i] = 1'b0;
        end else begin : g_mid
            assign left_e[i]  = cell_q[i-1];
            assign left_lt[i] = lt_v[i-1];
            assign left_fd[i] = found_v[i-1];
        end
        if (i == LAST) begin : g_last
            assign right_e[i] = '0;
        end else begin : g_inner
            assign right_e[i] = cell_q[i+1];
        end
        assign valid_vec[i] = cell_q[i].valid;

        edfq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .left_entry (left_e[i]),
            .left_lt    (left_lt[i]),
            .left_found (left_fd[i]),
            .right_entry(right_e[i]),
            .entry      (cell_q[i]),
            .lt         (lt_v[i]),
            .match      (match_v[i]),
            .found      (found_v[i])
        );
    end

    // Capture status and head changes while the row updates.
    always_comb begin
        status_next  = status_reg;
        preempt_next = preempt_reg;
        demoted_next = demoted_reg;
        head_rm_next = head_rm_reg;
        if (seq.capture_insert) begin
            status_next  = full ? STATUS_FULL : STATUS_OK;
            preempt_next = !full && cell_q[0].valid && lt_v[0];
            demoted_next = (!full && cell_q[0].valid && lt_v[0]) ?
                           cell_q[0].task_id : '0;
            head_rm_next = 1'b0;
        end else if (seq.capture_remove) begin
            status_next  = found_v[LAST] ? STATUS_OK : STATUS_NOT_FOUND;
            preempt_next = 1'b0;
            demoted_next = '0;
            head_rm_next = match_v[0];
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        preempt_reg <= preempt_next;
        demoted_reg <= demoted_next;
        head_rm_reg <= head_rm_next;
    end

    // Output register: loaded from the updated head.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (seq.load_result) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = status_reg;
            m_tdata_next  = {1'b0,
                             head_rm_reg && cell_q[0].valid,
                             demoted_reg,
                             preempt_reg,
                             cell_q[0].valid ? cell_q[0].task_id : {TASK_W{1'b0}},
                             cell_q[0].valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Occupied cells stay packed at the head end.
    `EDFQ_ASSERT(a_packed, aclk, aresetn, (valid_vec & (valid_vec + 1'b1)) == '0, "queue not packed")
    // An insert into a queue with room adds exactly one entry.
    `EDFQ_ASSERT(a_insert_count, aclk, aresetn, (ctrl.op == CELL_INSERT) |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1), "insert count wrong")
    // A removal of a queued task drops exactly one entry.
    `EDFQ_ASSERT(a_remove_count, aclk, aresetn, (ctrl.op == CELL_REMOVE && found_v[LAST]) |=> ($countones(valid_vec) + 1 == $past($countones(valid_vec))), "remove count wrong")
    // A result never reports both a preemption and a promotion.
    `EDFQ_ASSERT(a_excl_flags, aclk, aresetn, m_tvalid |-> !(m_tdata[7] && m_tdata[14]), "preempt with promote")
    // Nothing is accepted while an item is still in work.
    `EDFQ_ASSERT_ALWAYS(a_one_item, aclk, (aresetn && accept) |=> !s_tready, "second item accepted")

endmodule

/* src/edfq_cell.sv */
module edfq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  edfq_pkg::cell_ctrl_t ctrl,
    input  edfq_pkg::entry_t    left_entry,
    input  logic                left_lt,
    input  logic                left_found,
    input  edfq_pkg::entry_t    right_entry,
    output edfq_pkg::entry_t    entry,
    output logic                lt,
    output logic                match,
    output logic                found
);
    import edfq_pkg::*;

    logic              valid_reg, valid_next;
    logic [TASK_W-1:0] task_reg, task_next;
    logic [DL_W-1:0]   dl_reg, dl_next;
    logic              fb_reg, fb_next;

    // An empty cell or a later deadline sits behind the newcomer.
    assign lt    = !valid_reg || (ctrl.deadline < dl_reg);
    assign match = valid_reg && (task_reg == ctrl.task_id);
    assign found = fb_reg || match;
    assign entry = '{valid: valid_reg, task_id: task_reg, deadline: dl_reg};

    // Per-cell update: shift right on insert, shift left on removal; clear or step the found-before flag.
    always_comb begin
        valid_next = valid_reg;
        task_next  = task_reg;
        dl_next    = dl_reg;
        fb_next    = fb_reg;
        case (ctrl.op)
            CELL_CLEAR: begin
                fb_next = 1'b0;
            end
            CELL_STEP: begin
                fb_next = left_found;
            end
            CELL_INSERT: begin
                if (lt) begin
                    if (left_lt) begin
                        valid_next = left_entry.valid;
                        task_next  = left_entry.task_id;
                        dl_next    = left_entry.deadline;
                    end else begin
                        valid_next = 1'b1;
                        task_next  = ctrl.task_id;
                        dl_next    = ctrl.deadline;
                    end
                end
            end
            CELL_REMOVE: begin
                if (found) begin
                    valid_next = right_entry.valid;
                    task_next  = right_entry.task_id;
                    dl_next    = right_entry.deadline;
                end
            end
            default: begin
            end
        endcase
    end

    // Control bits are reset; the payload is qualified by valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            fb_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            fb_reg    <= fb_next;
        end
        task_reg <= task_next;
        dl_reg   <= dl_next;
    end

endmodule

/* src/edfq_seq.sv */
module edfq_seq #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                cmd,
    input  logic                out_free,
    output edfq_pkg::seq_ctrl_t seq
);
    import edfq_pkg::*;

    localparam int CNT_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUEUE_DEPTH - 2);

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Next state and step counter.
    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = (cmd == CMD_RELEASE) ? S_INSERT : S_WAVE;
                end
            end
            S_INSERT: begin
                state_next = S_RESULT;
            end
            S_WAVE: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = S_REMOVE;
                end
            end
            S_REMOVE: begin
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb begin
        seq = '{op: CELL_HOLD, capture_insert: 1'b0, capture_remove: 1'b0,
                load_result: 1'b0, idle: 1'b0};
        case (state_reg)
            S_IDLE: begin
                seq.op   = CELL_CLEAR;
                seq.idle = 1'b1;
            end
            S_INSERT: begin
                seq.op             = CELL_INSERT;
                seq.capture_insert = 1'b1;
            end
            S_WAVE: begin
                seq.op = CELL_STEP;
            end
            S_REMOVE: begin
                seq.op             = CELL_REMOVE;
                seq.capture_remove = 1'b1;
            end
            S_RESULT: begin
                seq.load_result = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
